>>> sv/psq_pkg.sv
// Package for the priority semaphore wait queue.
// Holds the queue entry type, request codes, cell control struct and ordering function.
// No dependencies; imported by the cell and the top level.
package psq_pkg;

  // Request codes
  typedef enum logic [1:0] {
    REQ_DOWN  = 2'd0,
    REQ_UP    = 2'd1,
    REQ_BOOST = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // One waiter as held in a cell
  typedef struct packed {
    logic [7:0]  id;
    logic        urgent;
    logic [15:0] deadline;
    logic [15:0] arrival;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic clear;    // empty the queue
    logic cmp_ins;  // 1: hit means "new entry goes here", 0: hit means id match
    logic ins;      // insert new entry at first hit
    logic wake;     // pop head, shift toward head
    logic boost;    // move first id match to the head
  } ctl_t;

  localparam int COUNT_W   = 5;
  localparam int COUNT_MAX = 31;

  // True when entry a is served strictly before entry b
  function automatic logic beats(entry_t a, entry_t b);
    logic r;
    if (a.urgent != b.urgent) begin
      r = a.urgent;
    end else if (a.urgent && (a.deadline != b.deadline)) begin
      r = a.deadline < b.deadline;
    end else begin
      r = a.arrival < b.arrival;
    end
    return r;
  endfunction

endpackage

>>> sv/psq_if.sv
// Channel interfaces for the priority semaphore wait queue: request, response, config.
// Each carries valid, ready and payload with source and sink modports.
// Depends on nothing.
interface psq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  vehicle_id;
  logic        is_urgent;
  logic [15:0] deadline;
  logic [15:0] arrival_time;

  modport source (output valid, req_type, vehicle_id, is_urgent, deadline, arrival_time,
                  input ready);
  modport sink   (input valid, req_type, vehicle_id, is_urgent, deadline, arrival_time,
                  output ready);
endinterface

interface psq_rsp_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic       queued;
  logic       rejected_full;
  logic       woken_valid;
  logic [7:0] woken_id;
  logic       boost_found;
  logic [7:0] permits_now;
  logic [4:0] waiting_count;
  logic [4:0] urgent_waiting;

  modport source (output valid, granted, queued, rejected_full, woken_valid, woken_id,
                  boost_found, permits_now, waiting_count, urgent_waiting,
                  input ready);
  modport sink   (input valid, granted, queued, rejected_full, woken_valid, woken_id,
                  boost_found, permits_now, waiting_count, urgent_waiting,
                  output ready);
endinterface

interface psq_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] initial_permits;

  modport source (output valid, initial_permits, input ready);
  modport sink   (input valid, initial_permits, output ready);
endinterface

>>> sv/psq_cell.sv
// One slot of the sorted wait queue: holds an entry and its valid bit.
// Exchanges entries with both neighbors and ripples a first-hit chain.
// Depends on psq_pkg.
module psq_cell (
  input  logic            clk,
  input  logic            rst,
  input  psq_pkg::ctl_t   ctl,
  input  psq_pkg::entry_t new_entry,
  input  logic [7:0]      match_id,
  input  psq_pkg::entry_t left_entry,
  input  logic            left_valid,
  input  psq_pkg::entry_t right_entry,
  input  logic            right_valid,
  input  logic            hit_in,
  output logic            hit_out,
  input  psq_pkg::entry_t carry_in,
  output psq_pkg::entry_t carry_out,
  output psq_pkg::entry_t entry,
  output logic            valid
);
  import psq_pkg::*;

  logic hit_mine;
  logic first;

  // Local compare: insertion point or id match
  always_comb begin
    if (ctl.cmp_ins) begin
      hit_mine = !valid || beats(new_entry, entry);
    end else begin
      hit_mine = valid && (entry.id == match_id);
    end
    first     = hit_mine && !hit_in;
    hit_out   = hit_in || hit_mine;
    carry_out = first ? entry : carry_in;
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      if (hit_in) begin
        valid <= left_valid;
      end else if (first) begin
        valid <= 1'b1;
      end
    end else if (ctl.wake) begin
      valid <= right_valid;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (hit_in) begin
        entry <= left_entry;
      end else if (first) begin
        entry <= new_entry;
      end
    end else if (ctl.wake) begin
      entry <= right_entry;
    end else if (ctl.boost && !hit_in) begin
      // head side of the match shifts back; head cell's left is the moved entry
      entry <= left_entry;
    end
  end

endmodule

>>> sv/priority_semaphore_wait_queue_top.sv
// Top level of the priority semaphore wait queue: permit counter, cell chain, result register.
// Depends on psq_pkg, psq_if (interfaces) and psq_cell.
//
//  channel  dir  role
//  req      in   down / up / boost request transaction
//  rsp      out  one result transaction per request
//  cfg      in   initial_permits write; reloads the count and empties the queue
//
// Each request is decided in the cycle it is accepted; the cell row, the permit count
// and the output register that holds the result all update at that edge.
// One request per cycle is taken while rsp is drained; a stalled rsp holds req off.
// Synchronous reset loads one permit and empties the queue; no clearing pass.
module priority_semaphore_wait_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic    clk,
  input logic    rst,
  psq_req_if.sink   req,
  psq_rsp_if.source rsp,
  psq_cfg_if.sink   cfg
);
  import psq_pkg::*;

  localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

  // State
  logic [7:0]       permit;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] urg_cnt;
  logic [7:0]       permit_next;
  logic [LEN_W-1:0] len_next;
  logic [LEN_W-1:0] urg_cnt_next;

  // Cell row wiring
  entry_t                 ent   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vld;
  logic [QUEUE_DEPTH:0]   hit;
  entry_t                 carry [QUEUE_DEPTH+1];
  entry_t                 new_entry;
  ctl_t                   ctl;

  // Result register
  logic       rsp_valid;
  logic       granted;
  logic       queued;
  logic       rejected_full;
  logic       woken_valid;
  logic [7:0] woken_id;
  logic       boost_found;
  logic       g_next, q_next, r_next, w_next, b_next;
  logic [7:0] wid_next;

  logic acc;
  logic full;

  assign req.ready = !rsp_valid || rsp.ready;
  assign cfg.ready = 1'b1;
  assign acc       = req.valid && req.ready;
  assign full      = (len == LEN_W'(QUEUE_DEPTH));

  assign new_entry.id       = req.vehicle_id;
  assign new_entry.urgent   = req.is_urgent;
  assign new_entry.deadline = req.deadline;
  assign new_entry.arrival  = req.arrival_time;

  assign hit[0]   = 1'b0;
  assign carry[0] = ent[0];

  // Chain of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    logic   left_v;
    entry_t right_e;
    logic   right_v;

    if (i == 0) begin : g_head
      assign left_e = carry[QUEUE_DEPTH];
      assign left_v = 1'b0;
    end else begin : g_mid
      assign left_e = ent[i-1];
      assign left_v = vld[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = ent[i];
      assign right_v = 1'b0;
    end else begin : g_body
      assign right_e = ent[i+1];
      assign right_v = vld[i+1];
    end

    psq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .match_id    (req.vehicle_id),
      .left_entry  (left_e),
      .left_valid  (left_v),
      .right_entry (right_e),
      .right_valid (right_v),
      .hit_in      (hit[i]),
      .hit_out     (hit[i+1]),
      .carry_in    (carry[i]),
      .carry_out   (carry[i+1]),
      .entry       (ent[i]),
      .valid       (vld[i])
    );
  end

  // Request decode and next state
  always_comb begin
    ctl          = '0;
    ctl.clear    = cfg.valid;
    ctl.cmp_ins  = (req.req_type == REQ_DOWN);
    permit_next  = permit;
    len_next     = len;
    urg_cnt_next = urg_cnt;
    g_next       = 1'b0;
    q_next       = 1'b0;
    r_next       = 1'b0;
    w_next       = 1'b0;
    b_next       = 1'b0;
    wid_next     = 8'd0;
    case (req.req_type)
      REQ_DOWN: begin
        if (permit != 8'd0) begin
          permit_next = permit - 8'd1;
          g_next      = 1'b1;
        end else if (full) begin
          r_next = 1'b1;
        end else begin
          ctl.ins      = acc;
          len_next     = len + LEN_W'(1);
          urg_cnt_next = urg_cnt + LEN_W'(req.is_urgent);
          q_next       = 1'b1;
        end
      end
      REQ_UP: begin
        if (len != '0) begin
          ctl.wake     = acc;
          w_next       = 1'b1;
          wid_next     = ent[0].id;
          len_next     = len - LEN_W'(1);
          urg_cnt_next = urg_cnt - LEN_W'(ent[0].urgent);
        end else if (permit != 8'hFF) begin
          permit_next = permit + 8'd1;
        end
      end
      REQ_BOOST: begin
        ctl.boost = acc && hit[QUEUE_DEPTH];
        b_next    = hit[QUEUE_DEPTH];
      end
      default: begin
      end
    endcase
  end

  // Permit count and queue counters
  always_ff @(posedge clk) begin
    if (rst) begin
      permit  <= 8'd1;
      len     <= '0;
      urg_cnt <= '0;
    end else if (cfg.valid) begin
      permit  <= cfg.initial_permits;
      len     <= '0;
      urg_cnt <= '0;
    end else if (acc) begin
      permit  <= permit_next;
      len     <= len_next;
      urg_cnt <= urg_cnt_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (acc) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      granted        <= g_next;
      queued         <= q_next;
      rejected_full  <= r_next;
      woken_valid    <= w_next;
      woken_id       <= wid_next;
      boost_found    <= b_next;
      rsp.permits_now    <= permit_next;
      rsp.waiting_count  <= (32'(len_next) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                         : COUNT_W'(len_next);
      rsp.urgent_waiting <= (32'(urg_cnt_next) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                             : COUNT_W'(urg_cnt_next);
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.granted       = granted;
  assign rsp.queued        = queued;
  assign rsp.rejected_full = rejected_full;
  assign rsp.woken_valid   = woken_valid;
  assign rsp.woken_id      = woken_id;
  assign rsp.boost_found   = boost_found;

  // Checks
  a_len_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) == int'(len))
    else $error("queue length disagrees with cell valid bits");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((vld + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1}) & vld) == '0)
    else $error("valid cells do not form a prefix");

  a_urgent_bound: assert property (@(posedge clk) disable iff (rst)
    urg_cnt <= len)
    else $error("urgent count exceeds queue length");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot0({granted, queued, rejected_full, woken_valid, boost_found}))
    else $error("more than one outcome flag in a result");

  a_wake_pops: assert property (@(posedge clk) disable iff (rst)
    (acc && ctl.wake && !cfg.valid) |=> (len == $past(len) - LEN_W'(1)))
    else $error("wake did not shorten the queue");

endmodule
